/* rtl/core/mia_pkg.sv */
// ---------------------------------------------------------------------------
// mia_pkg
// Shared constants and types for the cyclic identifier allocator: identifier
// and capacity widths, command and status codes, and the bitmap request type.
// ---------------------------------------------------------------------------
package mia_pkg;

	localparam int unsigned MAX_IDS   = 4096;
	localparam int unsigned INIT_CAP  = 256;
	localparam int unsigned ID_W      = $clog2(MAX_IDS);
	localparam int unsigned CAP_W     = ID_W + 1;
	localparam int unsigned RESET_CAP = (INIT_CAP > MAX_IDS) ? MAX_IDS : INIT_CAP;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_RELEASED  = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	typedef struct packed {
		logic            rd_en;
		logic            wr_en;
		logic [ID_W-1:0] addr;
		logic            wdata;
	} map_req_t;

endpackage

/* rtl/core/mia_map.sv */
// ---------------------------------------------------------------------------
// mia_map
// Used-slot bitmap: one bit per identifier in a single-port memory with a
// registered read, cleared by a sweep of one entry per cycle after reset.
// ---------------------------------------------------------------------------
module mia_map (
	input  logic              clk,
	input  logic              arst_n,
	input  mia_pkg::map_req_t req,
	output logic              rdata,
	output logic              clearing
);
	import mia_pkg::*;

	logic [ID_W:0] clr_q;
	logic          mem_q [MAX_IDS];
	logic          rdata_q;

	// top bit of the sweep counter sets once every entry has been written
	assign clearing = ~clr_q[ID_W];
	assign rdata    = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem_q[clr_q[ID_W-1:0]] <= 1'b0;
		end else if (req.wr_en) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.addr];
		end
	end

endmodule

/* rtl/core/monotonic_id_allocator_top.sv */
// ---------------------------------------------------------------------------
// monotonic_id_allocator_top
// Cyclic identifier allocator: grants identifiers from a growing pool by a
// slot-by-slot scan of a used bitmap, and frees them on release.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall): cmd selects allocate or release, and
// release_id names the slot to free. One command is in flight at a time;
// in_stall stays high from the transfer until its result is registered.
// Output channel (out_valid / out_stall): status and granted_id, one result
// per command, held in an output register while out_stall is high.
// Release: a valid release clears its bitmap bit at the transfer, and the
// result goes from the result state into the output register.
// Allocate: each look at a slot passes the address state (bitmap address)
// and then the check state (registered read); a grow step is an extra pass
// through the address state. The registered bitmap read and the single shared
// pointer increment and compare set this sequence.
// After reset the bitmap is swept clear, one entry per cycle, during which
// in_stall is high. Pointer resets to 1, capacity to 256.
// A stalled receiver holds the result; the next command may still be taken
// but its result waits until the output register is free.
// ---------------------------------------------------------------------------
module monotonic_id_allocator_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic [mia_pkg::ID_W-1:0]  release_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [mia_pkg::ID_W-1:0]  granted_id
);
	import mia_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADDR,
		S_CHECK,
		S_RESULT
	} state_t;

	state_t           state_q;
	logic [ID_W-1:0]  next_slot_q;
	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] look_q;
	logic [ID_W-1:0]  cand_q;
	logic [1:0]       res_st_q;
	logic [ID_W-1:0]  res_id_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [ID_W-1:0]  granted_id_q;

	map_req_t         map_req;
	logic             map_rdata;
	logic             clearing;

	logic             in_xfer;
	logic             rel_ok;
	logic             pass_done;
	logic             hit;
	logic [CAP_W-1:0] succ;
	logic [ID_W-1:0]  nxt;
	logic [CAP_W:0]   doubled;
	logic [CAP_W-1:0] grown;

	mia_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (map_req),
		.rdata    (map_rdata),
		.clearing (clearing)
	);

	assign in_stall   = (state_q != S_IDLE) || clearing;
	assign in_xfer    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign granted_id = granted_id_q;

	assign rel_ok    = (release_id != '0) && ({1'b0, release_id} < cap_q);
	assign pass_done = (look_q >= cap_q);
	assign hit       = (cand_q != '0) && ({1'b0, cand_q} < cap_q) && !map_rdata;

	// pointer step with wrap
	always_comb begin
		succ = {1'b0, next_slot_q} + 1'b1;
		if (succ >= cap_q) begin
			nxt = (cap_q >= CAP_W'(2)) ? ID_W'(2) : ID_W'(1);
		end else begin
			nxt = succ[ID_W-1:0];
		end
	end

	always_comb begin
		doubled = {cap_q, 1'b0};
		if (doubled > (CAP_W+1)'(MAX_IDS)) begin
			grown = CAP_W'(MAX_IDS);
		end else begin
			grown = doubled[CAP_W-1:0];
		end
	end

	always_comb begin
		map_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && cmd == CMD_RELEASE && rel_ok) begin
					map_req.wr_en = 1'b1;
					map_req.addr  = release_id;
					map_req.wdata = 1'b0;
				end
			end
			S_ADDR: begin
				if (!pass_done) begin
					map_req.rd_en = 1'b1;
					map_req.addr  = next_slot_q;
				end
			end
			S_CHECK: begin
				if (hit) begin
					map_req.wr_en = 1'b1;
					map_req.addr  = cand_q;
					map_req.wdata = 1'b1;
				end
			end
			S_RESULT: begin
				map_req = '0;
			end
			default: begin
				map_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			next_slot_q  <= ID_W'(1);
			cap_q        <= CAP_W'(RESET_CAP);
			look_q       <= '0;
			cand_q       <= '0;
			res_st_q     <= ST_ALLOCATED;
			res_id_q     <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_ALLOCATED;
			granted_id_q <= '0;
		end else begin
			// the result state reloads the output register itself
			if (out_valid_q && !out_stall && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						look_q <= '0;
						if (cmd == CMD_ALLOC) begin
							state_q <= S_ADDR;
						end else begin
							res_st_q <= rel_ok ? ST_RELEASED : ST_RANGE;
							res_id_q <= '0;
							state_q  <= S_RESULT;
						end
					end
				end
				S_ADDR: begin
					if (!pass_done) begin
						cand_q      <= next_slot_q;
						next_slot_q <= nxt;
						look_q      <= look_q + 1'b1;
						state_q     <= S_CHECK;
					end else if (cap_q >= CAP_W'(MAX_IDS)) begin
						res_st_q <= ST_EXHAUSTED;
						res_id_q <= '0;
						state_q  <= S_RESULT;
					end else begin
						// full pass without a free slot: grow and resume at the old top
						cap_q       <= grown;
						next_slot_q <= cap_q[ID_W-1:0];
						look_q      <= '0;
					end
				end
				S_CHECK: begin
					if (hit) begin
						res_st_q <= ST_ALLOCATED;
						res_id_q <= cand_q;
						state_q  <= S_RESULT;
					end else begin
						state_q <= S_ADDR;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_st_q;
						granted_id_q <= res_id_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cap_grows_only: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q >= $past(cap_q))
		else $error("live capacity shrank");

	a_ptr_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, next_slot_q} < cap_q)
		else $error("next slot pointer outside live capacity");

	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_ALLOCATED |-> granted_id_q != '0)
		else $error("slot zero granted");

	a_id_only_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_ALLOCATED |-> granted_id_q == '0)
		else $error("identifier on a result that is not a grant");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q != S_IDLE)
		else $error("command transfer did not start work");
`endif

endmodule
